// ----- hw/rtl/slbc_pkg.sv -----
// Shared types, register indexes and reset constants for the status LED blink code block.
package slbc_pkg;

    localparam int PROFILE_COUNT    = 8;
    localparam int STARTUP_DELAY_MS = 1000;

    localparam int MS_W    = 16;
    localparam int PULSE_W = 4;
    localparam int INDEX_W = 3;
    localparam int REG_W   = 3;

    localparam logic [PULSE_W-1:0] PROFILE_LAST = PULSE_W'(PROFILE_COUNT - 1);

    localparam logic [REG_W-1:0] REG_SHORT_PULSE   = 3'd0;
    localparam logic [REG_W-1:0] REG_LONG_PULSE    = 3'd1;
    localparam logic [REG_W-1:0] REG_GAP           = 3'd2;
    localparam logic [REG_W-1:0] REG_PAUSE         = 3'd3;
    localparam logic [REG_W-1:0] REG_RESTART_DELAY = 3'd4;

    localparam logic [MS_W-1:0] SHORT_PULSE_RST   = 16'd100;
    localparam logic [MS_W-1:0] LONG_PULSE_RST    = 16'd400;
    localparam logic [MS_W-1:0] GAP_RST           = 16'd250;
    localparam logic [MS_W-1:0] PAUSE_RST         = 16'd2500;
    localparam logic [MS_W-1:0] RESTART_DELAY_RST = 16'd600;
    localparam logic [MS_W-1:0] STARTUP_DELAY     = MS_W'(STARTUP_DELAY_MS);

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_CHANGE = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0] short_pulse_ms;
        logic [MS_W-1:0] long_pulse_ms;
        logic [MS_W-1:0] gap_ms;
        logic [MS_W-1:0] pause_ms;
        logic [MS_W-1:0] restart_delay_ms;
    } slbc_cfg_t;

endpackage

// ----- hw/rtl/slbc_cfg_regs.sv -----
// Configuration register file for the blink timing values.
module slbc_cfg_regs
    import slbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_W-1:0]     cfg_index,
    input  logic [MS_W-1:0]      cfg_data,
    output slbc_cfg_t            cfg
);

    slbc_cfg_t cfg_reg;
    slbc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SHORT_PULSE:   cfg_next.short_pulse_ms   = cfg_data;
                REG_LONG_PULSE:    cfg_next.long_pulse_ms    = cfg_data;
                REG_GAP:           cfg_next.gap_ms           = cfg_data;
                REG_PAUSE:         cfg_next.pause_ms         = cfg_data;
                REG_RESTART_DELAY: cfg_next.restart_delay_ms = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_pulse_ms   <= SHORT_PULSE_RST;
            cfg_reg.long_pulse_ms    <= LONG_PULSE_RST;
            cfg_reg.gap_ms           <= GAP_RST;
            cfg_reg.pause_ms         <= PAUSE_RST;
            cfg_reg.restart_delay_ms <= RESTART_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/slbc_core.sv -----
// Blink sequencer: millisecond down-counter, pulse counter and LED state.
module slbc_core
    import slbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 cmd,
    input  logic [INDEX_W-1:0]   profile_index,
    input  logic                 link_connected,
    input  slbc_cfg_t            cfg,
    output logic                 lit_next
);

    logic [MS_W-1:0]    delay_left_reg, delay_left_next;
    logic               restart_pending_reg, restart_pending_next;
    logic               lit_reg;
    logic [PULSE_W-1:0] pulses_left_reg, pulses_left_next;
    logic [MS_W-1:0]    pulse_length_reg, pulse_length_next;

    logic               step_fire;
    logic               cur_lit;
    logic [PULSE_W-1:0] cur_pulses;
    logic [PULSE_W-1:0] dec_pulses;
    logic [PULSE_W-1:0] sat_index;
    logic [MS_W-1:0]    new_length;

    assign step_fire = en && (cmd == CMD_TICK) && (delay_left_reg <= MS_W'(1));

    // A pending restart wipes the pulse state before the step.
    assign cur_lit    = restart_pending_reg ? 1'b0 : lit_reg;
    assign cur_pulses = restart_pending_reg ? '0 : pulses_left_reg;
    assign dec_pulses = cur_pulses - PULSE_W'(1);

    always_comb
    begin
        sat_index = {1'b0, profile_index};
        if (sat_index > PROFILE_LAST)
            sat_index = PROFILE_LAST;
    end

    assign new_length = link_connected ? cfg.short_pulse_ms : cfg.long_pulse_ms;

    always_comb
    begin
        delay_left_next      = delay_left_reg;
        restart_pending_next = restart_pending_reg;
        lit_next             = lit_reg;
        pulses_left_next     = pulses_left_reg;
        pulse_length_next    = pulse_length_reg;
        if (en)
        begin
            priority if (cmd == CMD_CHANGE)
            begin
                restart_pending_next = 1'b1;
                delay_left_next      = cfg.restart_delay_ms;
            end
            else if (delay_left_reg > MS_W'(1))
            begin
                delay_left_next = delay_left_reg - MS_W'(1);
            end
            else
            begin
                restart_pending_next = 1'b0;
                if (cur_lit)
                begin
                    lit_next         = 1'b0;
                    pulses_left_next = dec_pulses;
                    delay_left_next  = (dec_pulses != '0) ? cfg.gap_ms : cfg.pause_ms;
                end
                else if (cur_pulses == '0)
                begin
                    // Start a new group.
                    lit_next          = 1'b1;
                    pulses_left_next  = sat_index + PULSE_W'(1);
                    pulse_length_next = new_length;
                    delay_left_next   = new_length;
                end
                else
                begin
                    lit_next         = 1'b1;
                    pulses_left_next = cur_pulses;
                    delay_left_next  = pulse_length_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_left_reg      <= STARTUP_DELAY;
            restart_pending_reg <= 1'b1;
            lit_reg             <= 1'b0;
            pulses_left_reg     <= '0;
            pulse_length_reg    <= '0;
        end
        else
        begin
            delay_left_reg      <= delay_left_next;
            restart_pending_reg <= restart_pending_next;
            lit_reg             <= lit_next;
            pulses_left_reg     <= pulses_left_next;
            pulse_length_reg    <= pulse_length_next;
        end
    end

    a_lit_has_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        lit_reg |-> (pulses_left_reg != '0))
        else $error("LED lit with no pulse left");

    a_step_clears_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> !restart_pending_reg)
        else $error("restart still pending after a step");

    a_change_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        (en && cmd == CMD_CHANGE) |=>
            (restart_pending_reg && delay_left_reg == $past(cfg.restart_delay_ms)))
        else $error("change event did not reload restart delay");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(delay_left_reg) && $stable(lit_reg) && $stable(pulses_left_reg)))
        else $error("state moved without a transaction");

endmodule

// ----- hw/rtl/status_led_blink_code.sv -----
// Top level: input register, blink sequencer and result register.
// An accepted transaction is held in the input register, and its result then in the result register.
// Throughput: one item per cycle while the result register is not stalled.
// Back-pressure: the input stalls only when the input register holds an item
// and the result register is full and stalled.
// Reset: asynchronous, active low; timing registers take their defaults and the
// sequencer starts as if initialization had just completed (restart pending).
module status_led_blink_code
    import slbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [INDEX_W-1:0]   profile_index,
    input  logic                 link_connected,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 led_level,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_W-1:0]     cfg_index,
    input  logic [MS_W-1:0]      cfg_data
);

    slbc_cfg_t          cfg;
    logic               in_valid_reg;
    logic               cmd_reg;
    logic [INDEX_W-1:0] profile_index_reg;
    logic               link_connected_reg;
    logic               out_valid_reg;
    logic               led_level_reg;
    logic               advance;
    logic               lit_next;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign led_level = led_level_reg;

    slbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slbc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (in_valid_reg && advance),
        .cmd            (cmd_reg),
        .profile_index  (profile_index_reg),
        .link_connected (link_connected_reg),
        .cfg            (cfg),
        .lit_next       (lit_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload: capture a new transaction, hold the result while stalled.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg            <= cmd;
            profile_index_reg  <= profile_index;
            link_connected_reg <= link_connected;
        end
        if (advance && in_valid_reg)
            led_level_reg <= lit_next;
    end

endmodule
